// ===== sv/dds_twl_pkg.sv =====
// ----------------------------------------------------------------------------
// DDS tuning word loader package
// Shared widths, constants and types for the tuning word divider and the
// serial pulse sequencer.
// ----------------------------------------------------------------------------
package dds_twl_pkg;

	localparam int WORD_BITS = 40;
	localparam int BITS_W = $clog2(WORD_BITS + 1);

	localparam int FREQ_W = 32;
	localparam int CTRL_W = 8;
	localparam int TW_W = 32;

	localparam int DIV_STEPS = FREQ_W + TW_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [31:0] REF_CLK_RESET = 32'd125000000;

	typedef struct packed {
		logic done;
		logic [TW_W-1:0] quot;
	} div_res_t;

	typedef struct packed {
		logic start;
		logic [WORD_BITS-1:0] word;
	} ser_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ser_sts_t;

endpackage

// ===== sv/dds_twl_div.sv =====
// ----------------------------------------------------------------------------
// DDS tuning word divider
// Restoring divider that forms the low 32 bits of (frequency * 2^32) / refclk,
// one quotient bit per cycle on a single shared subtract-and-compare unit.
// ----------------------------------------------------------------------------
module dds_twl_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [dds_twl_pkg::FREQ_W-1:0] freq,
	input  logic [31:0] divisor,
	output dds_twl_pkg::div_res_t res
);

	logic [dds_twl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic done_q;
	logic [dds_twl_pkg::DIV_STEPS-1:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [dds_twl_pkg::TW_W-1:0] quot_q;

	logic [32:0] trial;
	logic [32:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[dds_twl_pkg::DIV_STEPS-1]};
	assign ge = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= dds_twl_pkg::DIV_CNT_W'(dds_twl_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - dds_twl_pkg::DIV_CNT_W'(1);
				if (cnt_q == dds_twl_pkg::DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {freq, {dds_twl_pkg::TW_W{1'b0}}};
			rem_q <= '0;
			div_q <= divisor;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[dds_twl_pkg::DIV_STEPS-2:0], 1'b0};
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quot_q <= {quot_q[dds_twl_pkg::TW_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

// ===== sv/dds_twl_ser.sv =====
// ----------------------------------------------------------------------------
// DDS serial pulse sequencer
// Emits the serial-mode enable pulses once after reset, then one clock pulse
// per load bit, least significant bit first, and a closing update pulse.
// ----------------------------------------------------------------------------
module dds_twl_ser (
	input  logic clk,
	input  logic arst_n,
	input  dds_twl_pkg::ser_cmd_t cmd,
	output dds_twl_pkg::ser_sts_t sts,
	output logic out_valid,
	input  logic out_stall,
	output logic pulse_kind,
	output logic data_bit,
	output logic last_pulse
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EN_CLK = 5'b00010,
		S_EN_UPD = 5'b00100,
		S_BITS   = 5'b01000,
		S_UPD    = 5'b10000
	} state_t;

	state_t state_q;
	logic mode_q;
	logic done_q;
	logic [dds_twl_pkg::WORD_BITS-1:0] word_q;
	logic [dds_twl_pkg::BITS_W-1:0] bits_q;
	logic take;

	assign take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= 1'b0;
			done_q <= 1'b0;
			bits_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						bits_q <= dds_twl_pkg::BITS_W'(dds_twl_pkg::WORD_BITS);
						mode_q <= 1'b1;
						state_q <= mode_q ? S_BITS : S_EN_CLK;
					end
				end
				S_EN_CLK: begin
					if (take) begin
						state_q <= S_EN_UPD;
					end
				end
				S_EN_UPD: begin
					if (take) begin
						state_q <= S_BITS;
					end
				end
				S_BITS: begin
					if (take) begin
						bits_q <= bits_q - dds_twl_pkg::BITS_W'(1);
						if (bits_q == dds_twl_pkg::BITS_W'(1)) begin
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					if (take) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.start) begin
			word_q <= cmd.word;
		end else if (state_q == S_BITS && take) begin
			word_q <= {1'b0, word_q[dds_twl_pkg::WORD_BITS-1:1]};
		end
	end

	assign out_valid = state_q != S_IDLE;
	assign pulse_kind = state_q == S_EN_UPD || state_q == S_UPD;
	assign data_bit = state_q == S_BITS && word_q[0];
	assign last_pulse = state_q == S_UPD;

	assign sts.busy = state_q != S_IDLE;
	assign sts.done = done_q;

endmodule

// ===== sv/dds_tuning_word_serial_loader.sv =====
// An accepted item runs through the 64 divider steps, then the divider's done strobe starts
// the sequencer on its pulses; a new item is taken only once the sequencer reports done.
// Reset clears the sequencer, the serial-mode flag and sets the reference clock to 125 MHz.
// ----------------------------------------------------------------------------
// DDS tuning word serial loader
// Computes the DDS tuning word from a target frequency and streams the 40-bit
// load word out as serial clock pulses closed by a frequency update pulse.
// ----------------------------------------------------------------------------
module dds_tuning_word_serial_loader (
	input  logic clk,
	input  logic arst_n,
	input  logic reference_clock_hz_we,
	input  logic [31:0] reference_clock_hz_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic [31:0] target_frequency_hz,
	input  logic [7:0] control_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic pulse_kind,
	output logic data_bit,
	output logic last_pulse
);

	logic [31:0] ref_clk_q;
	logic busy_q;
	logic [dds_twl_pkg::CTRL_W-1:0] ctrl_q;
	logic accept;

	dds_twl_pkg::div_res_t div_res;
	dds_twl_pkg::ser_cmd_t ser_cmd;
	dds_twl_pkg::ser_sts_t ser_sts;

	assign accept = in_valid && !in_stall;
	assign in_stall = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clk_q <= dds_twl_pkg::REF_CLK_RESET;
			busy_q <= 1'b0;
		end else begin
			if (reference_clock_hz_we) begin
				ref_clk_q <= reference_clock_hz_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (ser_sts.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_q <= control_byte;
		end
	end

	dds_twl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.freq    (target_frequency_hz),
		.divisor (ref_clk_q),
		.res     (div_res)
	);

	assign ser_cmd.start = div_res.done;
	assign ser_cmd.word = dds_twl_pkg::WORD_BITS'({ctrl_q, div_res.quot});

	dds_twl_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ser_cmd),
		.sts        (ser_sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pulse_kind (pulse_kind),
		.data_bit   (data_bit),
		.last_pulse (last_pulse)
	);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDS tuning word serial loader testbench
// Drives frequency/control requests through the valid/stall handshake, with
// bursty input traffic, a patterned output stall and several reference clock
// settings. Every pulse is checked in order against a local model of the
// tuning word division and the serial load sequence.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic kind;
		logic data;
		logic last;
	} pulse_t;

	typedef struct packed {
		logic [31:0] ref_clk;
		logic [31:0] freq;
		logic [7:0] ctrl;
		logic tw_known;
		logic [31:0] tw;
	} load_row_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	localparam int DIRECTED_ROWS = 18;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 58;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic reference_clock_hz_we = 1'b0;
	logic [31:0] reference_clock_hz_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] target_frequency_hz = '0;
	logic [7:0] control_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic pulse_kind;
	logic data_bit;
	logic last_pulse;

	pulse_t pulse_queue [$];
	logic [31:0] ref_clk_model = dds_twl_pkg::REF_CLK_RESET;
	logic serial_mode_on = 1'b0;
	int mismatch_count = 0;
	int burst_left = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int stall_mode_left = 0;
	int stall_run = 0;
	int stall_period = 4;
	int stall_phase = 0;
	logic stall_next;

	load_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'd125000000, 32'd0,          8'h00, 1'b1, 32'h00000000},
		'{32'd125000000, 32'hFFFFFFFF,   8'hFF, 1'b0, 32'h00000000},
		'{32'd125000000, 32'd62500000,   8'hA5, 1'b1, 32'h80000000},
		'{32'd125000000, 32'd125000000,  8'h5A, 1'b1, 32'h00000000},
		'{32'd125000000, 32'd250000000,  8'h01, 1'b1, 32'h00000000},
		'{32'd125000000, 32'd10000000,   8'h80, 1'b0, 32'h00000000},
		'{32'd1,         32'd0,          8'h00, 1'b1, 32'h00000000},
		'{32'd1,         32'd1,          8'h7F, 1'b1, 32'h00000000},
		'{32'd1,         32'hFFFFFFFF,   8'hFF, 1'b1, 32'h00000000},
		'{32'hFFFFFFFF,  32'hFFFFFFFF,   8'h00, 1'b1, 32'h00000000},
		'{32'hFFFFFFFF,  32'd1,          8'hC3, 1'b1, 32'h00000001},
		'{32'hFFFFFFFF,  32'h7FFFFFFF,   8'h3C, 1'b0, 32'h00000000},
		'{32'd2,         32'd1,          8'h55, 1'b1, 32'h80000000},
		'{32'd2,         32'd3,          8'hAA, 1'b1, 32'h80000000},
		'{32'd0,         32'd0,          8'h00, 1'b1, 32'hFFFFFFFF},
		'{32'd0,         32'd12345,      8'hFF, 1'b1, 32'hFFFFFFFF},
		'{32'd3,         32'd1,          8'h0F, 1'b0, 32'h00000000},
		'{32'd125000000, 32'd1000,       8'hF0, 1'b0, 32'h00000000}
	};

	dds_tuning_word_serial_loader u_top (
		.clk(clk),
		.arst_n(arst_n),
		.reference_clock_hz_we(reference_clock_hz_we),
		.reference_clock_hz_wdata(reference_clock_hz_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_frequency_hz(target_frequency_hz),
		.control_byte(control_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_kind(pulse_kind),
		.data_bit(data_bit),
		.last_pulse(last_pulse)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [31:0] calc_tuning_word(input logic [31:0] freq,
			input logic [31:0] refclk);
		logic [63:0] num;
		if (refclk == 32'd0) begin
			return 32'hFFFFFFFF;
		end
		num = {freq, 32'd0};
		return 32'(num / {32'd0, refclk});
	endfunction

	task automatic queue_load_pulses(input logic [31:0] tw, input logic [7:0] ctrl);
		logic [63:0] load_word;
		load_word = {24'd0, ctrl, tw};
		if (!serial_mode_on) begin
			serial_mode_on = 1'b1;
			pulse_queue.push_back('{1'b0, 1'b0, 1'b0});
			pulse_queue.push_back('{1'b1, 1'b0, 1'b0});
		end
		for (int i = 0; i < dds_twl_pkg::WORD_BITS; i++) begin
			pulse_queue.push_back('{1'b0, load_word[i], 1'b0});
		end
		pulse_queue.push_back('{1'b1, 1'b0, 1'b1});
	endtask

	task automatic idle_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_sender($urandom_range(1, 120));
			burst_left = $urandom_range(0, 10);
		end
	endtask

	task automatic send_load(input logic [31:0] freq, input logic [7:0] ctrl,
			input logic tw_known, input logic [31:0] tw_given);
		logic [31:0] tw;
		@(negedge clk);
		in_valid <= 1'b1;
		target_frequency_hz <= freq;
		control_byte <= ctrl;
		do begin
			@(posedge clk);
		end while (in_stall !== 1'b0);
		tw = tw_known ? tw_given : calc_tuning_word(freq, ref_clk_model);
		queue_load_pulses(tw, ctrl);
		pace_sender();
	endtask

	task automatic drain_loads();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pulse_queue.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_ref_clock(input logic [31:0] value);
		drain_loads();
		reference_clock_hz_we <= 1'b1;
		reference_clock_hz_wdata <= value;
		@(negedge clk);
		reference_clock_hz_we <= 1'b0;
		ref_clk_model = value;
	endtask

	function automatic logic [31:0] random_frequency();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return (ref_clk_model == 32'd0) ? $urandom : $urandom % ref_clk_model;
			2: return $urandom_range(0, 1000);
			default: return ref_clk_model * $urandom_range(0, 3) - $urandom_range(0, 1);
		endcase
	endfunction

	always @(negedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_mode_left = $urandom_range(20, 300);
			stall_period = $urandom_range(2, 9);
		end else begin
			stall_mode_left--;
		end
		stall_phase = (stall_phase + 1) % stall_period;
		case (stall_mode)
			STALL_NONE: stall_next = 1'b0;
			STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
			default: stall_next = (stall_phase < stall_period / 2);
		endcase
		if (stall_run >= 8) begin
			stall_next = 1'b0;
		end
		stall_run = stall_next ? stall_run + 1 : 0;
		out_stall <= stall_next;
	end

	always @(posedge clk) begin
		pulse_t exp_pulse;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pulse_queue.size() == 0) begin
				$error("unexpected pulse: kind %0b data %0b last %0b",
					pulse_kind, data_bit, last_pulse);
				mismatch_count++;
			end else begin
				exp_pulse = pulse_queue.pop_front();
				if (pulse_kind !== exp_pulse.kind) begin
					$error("pulse_kind: expected %0b, got %0b", exp_pulse.kind, pulse_kind);
					mismatch_count++;
				end
				if (data_bit !== exp_pulse.data) begin
					$error("data_bit: expected %0b, got %0b", exp_pulse.data, data_bit);
					mismatch_count++;
				end
				if (last_pulse !== exp_pulse.last) begin
					$error("last_pulse: expected %0b, got %0b", exp_pulse.last, last_pulse);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic [31:0] phase_ref;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].ref_clk != ref_clk_model) begin
				set_ref_clock(directed_rows[i].ref_clk);
			end
			send_load(directed_rows[i].freq, directed_rows[i].ctrl,
				directed_rows[i].tw_known, directed_rows[i].tw);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: phase_ref = dds_twl_pkg::REF_CLK_RESET;
				1: phase_ref = $urandom;
				2: phase_ref = 32'd1;
				3: phase_ref = $urandom_range(2, 5000);
				4: phase_ref = 32'hFFFFFFFF;
				5: phase_ref = 32'd0;
				6: phase_ref = 32'd100000000;
				default: phase_ref = $urandom;
			endcase
			set_ref_clock(phase_ref);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_load(random_frequency(), 8'($urandom), 1'b0, 32'd0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pulse_queue.size() == 0);
		repeat (80) @(posedge clk);
		if (mismatch_count == 0 && pulse_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/dds_twl_pkg.sv
sv/dds_twl_div.sv
sv/dds_twl_ser.sv
sv/dds_tuning_word_serial_loader.sv
tb/sv/testbench.sv
